// ===== rtl/dgm_pkg.sv =====
// shared types and constants for the device group membership table
// used by dgm_ctrl, dgm_dp and the top level
`default_nettype none
package dgm_pkg;
  localparam int MaxDevices = 32;
  localparam int MaxGroups  = 16;
  localparam int SlotW  = $clog2(MaxDevices);
  localparam int DevCntW = $clog2(MaxDevices + 1);
  localparam int GrpIdxW = $clog2(MaxGroups);
  localparam int GrpCntW = $clog2(MaxGroups + 1);
  localparam int ListDepth = MaxDevices * MaxGroups;
  localparam int ListAddrW = SlotW + GrpIdxW;

  localparam logic [2:0] CmdAdd    = 3'd0;
  localparam logic [2:0] CmdRemove = 3'd1;
  localparam logic [2:0] CmdForget = 3'd2;
  localparam logic [2:0] CmdList   = 3'd3;
  localparam logic [2:0] CmdSet    = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,   // issue key read at search index
    ST_SRCH_CMP,  // compare registered key
    ST_DISPATCH,  // search done, decide action
    ST_ADD_RD,    // read list entry for duplicate scan
    ST_ADD_CMP,
    ST_ADD_WR,
    ST_ADD_NEW,
    ST_RM_RD,
    ST_RM_CMP,
    ST_SH_RD,     // shift: read entry k+1
    ST_SH_WR,     // shift: write entry k
    ST_RM_DONE,
    ST_FG_RD,     // forget: read last device key/count
    ST_FG_WR,
    ST_CP_RD,     // copy list entries of last into slot
    ST_CP_WR,
    ST_LS_RD,
    ST_LS_OUT,
    ST_RESULT
  } state_t;

  // controller commands to datapath
  typedef struct packed {
    logic load_in;     // capture input beat
    logic srch_clr;    // reset search index
    logic srch_inc;
    logic found_set;   // matched at search index
    logic key_rd;      // read key at search index
    logic cnt_rd;      // read count at found slot
    logic grp_rd_j;    // read list entry j of slot
    logic grp_rd_j1;   // read list entry j+1 of slot
    logic j_clr;
    logic j_inc;
    logic grp_wr_cnt;  // write gid at slot,count
    logic grp_wr_new;  // write gid at device_count,0
    logic grp_wr_j;    // write shifted data at slot,j
    logic cnt_wr_inc;  // count[slot] <= count+1
    logic cnt_wr_dec;
    logic new_dev;     // key,count for new device, device_count++
    logic last_rd;     // read key/count of last device
    logic mv_wr;       // write last key/count into slot, dev_count--
    logic dev_dec;     // device_count-- without move
    logic cp_rd;       // read list entry j of last
    logic cp_wr;       // write it to slot entry j
    logic ch_set;      // op changed flag <= 1
    logic ch_clr;
    logic set_flag_ld; // set_changed_so_far <= forget result
    logic set_flag_or; // set_changed_so_far |= op changed
    logic out_load;    // present a result beat
    logic out_list;    // result is a list beat
    logic fg_phase_clr;
    logic fg_phase_set; // set cmd: forget stage done, now add
  } dgm_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       set_first;
    logic       group_present;
    logic       fg_phase;
    logic       srch_end;     // index reached device_count
    logic       key_hit;
    logic       found;
    logic       full_table;
    logic       j_at_cnt;     // j reached count
    logic       j1_at_cnt;    // j+1 reached count
    logic       cnt_full;
    logic       cnt_is_one;
    logic       grp_hit;
    logic       slot_is_last;
    logic       list_zero;
    logic       list_last;    // j+1 == n
    logic       out_busy;     // result register holds an untaken beat
  } dgm_stat_t;
endpackage
`default_nettype wire

// ===== rtl/dgm_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module dgm_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/dgm_dp.sv =====
// datapath: captured beat, key/count/list rams, search and list indexes, result register
// depends on dgm_pkg and dgm_ram
`default_nettype none
module dgm_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dgm_pkg::dgm_cmd_t ctl,
  output dgm_pkg::dgm_stat_t     st,
  input  wire logic [2:0]        in_command,
  input  wire logic [63:0]       in_device_address,
  input  wire logic [15:0]       in_group_id,
  input  wire logic              in_set_first,
  input  wire logic              in_group_present,
  input  wire logic [4:0]        in_list_limit,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_changed,
  output logic [15:0]            out_listed_group,
  output logic                   out_listed_valid,
  output logic [4:0]             out_list_count,
  output logic                   out_last
);
  localparam int SW = dgm_pkg::SlotW;
  localparam int GW = dgm_pkg::GrpIdxW;
  localparam int CW = dgm_pkg::GrpCntW;
  localparam int DW = dgm_pkg::DevCntW;

  logic [2:0]  cmd_r;
  logic [63:0] key_r;
  logic [15:0] gid_r;
  logic        first_r, present_r;
  logic [4:0]  limit_r;
  logic [DW-1:0] dev_cnt_r;
  logic [DW-1:0] idx_r;      // one bit wider so a full table ends the search
  logic [SW-1:0] slot_r;
  logic          found_r, ch_r, set_flag_r, fg_phase_r;
  logic [CW-1:0] cnt_r;      // count of found slot, then of the moved device
  logic [CW-1:0] j_r;
  logic [CW-1:0] n_r;        // list answer length

  logic [63:0]   key_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   grp_q;
  logic [SW-1:0] last_slot;
  assign last_slot = SW'(dev_cnt_r - DW'(1));

  // key ram
  logic          key_we;
  logic [SW-1:0] key_wa, key_ra;
  logic [63:0]   key_wd;
  always_comb begin
    key_we = ctl.new_dev | ctl.mv_wr;
    key_wa = ctl.new_dev ? SW'(dev_cnt_r) : slot_r;
    key_wd = ctl.new_dev ? key_r : key_q;
    key_ra = ctl.last_rd ? last_slot : SW'(idx_r);
  end
  dgm_ram #(.Width(64), .Depth(dgm_pkg::MaxDevices)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
    .raddr(key_ra), .rdata(key_q));

  // count ram
  logic          cnt_we;
  logic [SW-1:0] cnt_wa, cnt_ra;
  logic [CW-1:0] cnt_wd;
  always_comb begin
    cnt_we = ctl.new_dev | ctl.mv_wr | ctl.cnt_wr_inc | ctl.cnt_wr_dec;
    cnt_wa = ctl.new_dev ? SW'(dev_cnt_r) : slot_r;
    if (ctl.new_dev) cnt_wd = CW'(1);
    else if (ctl.mv_wr) cnt_wd = cnt_q;
    else if (ctl.cnt_wr_inc) cnt_wd = cnt_r + CW'(1);
    else cnt_wd = cnt_r - CW'(1);
    cnt_ra = ctl.last_rd ? last_slot : SW'(idx_r);
  end
  dgm_ram #(.Width(CW), .Depth(dgm_pkg::MaxDevices)) u_cnts (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(cnt_ra), .rdata(cnt_q));

  // list ram
  logic                          grp_we;
  logic [dgm_pkg::ListAddrW-1:0] grp_wa, grp_ra;
  logic [15:0]                   grp_wd;
  always_comb begin
    grp_we = ctl.grp_wr_cnt | ctl.grp_wr_new | ctl.grp_wr_j | ctl.cp_wr;
    grp_wd = gid_r;
    if (ctl.grp_wr_new) grp_wa = {SW'(dev_cnt_r), GW'(0)};
    else if (ctl.grp_wr_cnt) grp_wa = {slot_r, GW'(cnt_r)};
    else grp_wa = {slot_r, GW'(j_r)};
    if (ctl.grp_wr_j | ctl.cp_wr) grp_wd = grp_q;
    // once the count has dropped, the moved device's old slot is the count
    if (ctl.cp_rd) grp_ra = {SW'(dev_cnt_r), GW'(j_r)};
    else if (ctl.grp_rd_j1) grp_ra = {slot_r, GW'(j_r + CW'(1))};
    else grp_ra = {slot_r, GW'(j_r)};
  end
  dgm_ram #(.Width(16), .Depth(dgm_pkg::ListDepth)) u_lists (
    .clk(clk), .we(grp_we), .waddr(grp_wa), .wdata(grp_wd),
    .raddr(grp_ra), .rdata(grp_q));

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_command; key_r <= in_device_address; gid_r <= in_group_id;
      first_r <= in_set_first; present_r <= in_group_present; limit_r <= in_list_limit;
    end
    if (ctl.found_set) slot_r <= SW'(idx_r);
    if (ctl.cnt_rd) cnt_r <= cnt_q;
    else if (ctl.mv_wr) cnt_r <= cnt_q;
    if (ctl.cnt_rd) n_r <= (CW'(cnt_q) > CW'(limit_r)) ? CW'(limit_r) : cnt_q;
    else if (ctl.srch_clr) n_r <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_cnt_r <= '0; idx_r <= '0; found_r <= 1'b0; ch_r <= 1'b0;
      set_flag_r <= 1'b0; fg_phase_r <= 1'b0; j_r <= '0;
    end else begin
      if (ctl.srch_clr) begin
        idx_r <= '0; found_r <= 1'b0;
      end else if (ctl.srch_inc) begin
        idx_r <= idx_r + DW'(1);
      end
      if (ctl.found_set) found_r <= 1'b1;
      if (ctl.new_dev) dev_cnt_r <= dev_cnt_r + DW'(1);
      else if (ctl.mv_wr | ctl.dev_dec) dev_cnt_r <= dev_cnt_r - DW'(1);
      if (ctl.j_clr) j_r <= '0;
      else if (ctl.j_inc) j_r <= j_r + CW'(1);
      if (ctl.ch_set) ch_r <= 1'b1;
      else if (ctl.ch_clr) ch_r <= 1'b0;
      if (ctl.set_flag_ld) set_flag_r <= ch_r;
      else if (ctl.set_flag_or) set_flag_r <= set_flag_r | ch_r;
      if (ctl.fg_phase_set) fg_phase_r <= 1'b1;
      else if (ctl.fg_phase_clr) fg_phase_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_last <= ctl.out_list ? (j_r + CW'(1) == n_r) : 1'b1;
      out_listed_group <= ctl.out_list ? grp_q : 16'd0;
      out_listed_valid <= ctl.out_list;
      out_list_count <= ctl.out_list ? 5'(n_r) : 5'd0;
      if (ctl.out_list || cmd_r == dgm_pkg::CmdList) out_changed <= 1'b0;
      else if (cmd_r == dgm_pkg::CmdSet) out_changed <= set_flag_r | (ctl.set_flag_or & ch_r);
      else if (cmd_r <= dgm_pkg::CmdForget) out_changed <= ch_r;
      else out_changed <= 1'b0;
    end
  end

  always_comb begin
    st.cmd = cmd_r;
    st.set_first = first_r;
    st.group_present = present_r;
    st.fg_phase = fg_phase_r;
    st.srch_end = idx_r >= dev_cnt_r;
    st.key_hit = key_q == key_r;
    st.found = found_r;
    st.full_table = dev_cnt_r >= DW'(dgm_pkg::MaxDevices);
    st.j_at_cnt = j_r >= cnt_r;
    st.j1_at_cnt = (j_r + CW'(1)) >= cnt_r;
    st.cnt_full = cnt_r >= CW'(dgm_pkg::MaxGroups);
    st.cnt_is_one = cnt_r == CW'(1);
    st.grp_hit = grp_q == gid_r;
    st.slot_is_last = slot_r == last_slot;
    st.list_zero = n_r == '0;
    st.list_last = (j_r + CW'(1)) == n_r;
    st.out_busy = out_valid & out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (dev_cnt_r <= DW'(dgm_pkg::MaxDevices))
        else $error("device count beyond table size");
    end
  end
  a_load_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !(out_valid & out_stall)) else $error("result overwritten");
  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.new_dev |-> dev_cnt_r < DW'(dgm_pkg::MaxDevices)) else $error("new device on full table");
  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mv_wr | ctl.dev_dec) |-> dev_cnt_r != '0) else $error("forget on empty table");
endmodule
`default_nettype wire

// ===== rtl/dgm_ctrl.sv =====
// controller state machine sequencing search, add, remove, forget, list and set
// depends on dgm_pkg
`default_nettype none
module dgm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dgm_pkg::dgm_stat_t st,
  output dgm_pkg::dgm_cmd_t       ctl
);
  dgm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dgm_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // which sub-operation the current pass performs
  logic op_add, op_rm, op_fg;
  always_comb begin
    op_add = st.cmd == dgm_pkg::CmdAdd || (st.cmd == dgm_pkg::CmdSet && st.fg_phase);
    op_rm  = st.cmd == dgm_pkg::CmdRemove;
    op_fg  = st.cmd == dgm_pkg::CmdForget || (st.cmd == dgm_pkg::CmdSet && !st.fg_phase);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dgm_pkg::ST_IDLE: if (in_valid) state_nxt = dgm_pkg::ST_SRCH_RD;
      dgm_pkg::ST_SRCH_RD:
        state_nxt = st.srch_end ? dgm_pkg::ST_DISPATCH : dgm_pkg::ST_SRCH_CMP;
      dgm_pkg::ST_SRCH_CMP:
        state_nxt = st.key_hit ? dgm_pkg::ST_DISPATCH : dgm_pkg::ST_SRCH_RD;
      dgm_pkg::ST_DISPATCH: begin
        if (st.cmd == dgm_pkg::CmdList) begin
          state_nxt = dgm_pkg::ST_LS_RD;
        end else if (st.cmd == dgm_pkg::CmdSet && !st.fg_phase && !st.set_first) begin
          state_nxt = st.group_present ? dgm_pkg::ST_SRCH_RD : dgm_pkg::ST_RESULT;
        end else if (op_add) begin
          state_nxt = st.found ? dgm_pkg::ST_ADD_RD
                    : (st.full_table ? dgm_pkg::ST_RESULT : dgm_pkg::ST_ADD_NEW);
        end else if (op_rm) begin
          state_nxt = st.found ? dgm_pkg::ST_RM_RD : dgm_pkg::ST_RESULT;
        end else if (op_fg) begin
          state_nxt = st.found ? dgm_pkg::ST_FG_RD
                    : ((st.cmd == dgm_pkg::CmdSet && st.group_present)
                       ? dgm_pkg::ST_SRCH_RD : dgm_pkg::ST_RESULT);
        end else begin
          state_nxt = dgm_pkg::ST_RESULT;
        end
      end
      dgm_pkg::ST_ADD_RD:
        state_nxt = st.j_at_cnt ? dgm_pkg::ST_ADD_WR : dgm_pkg::ST_ADD_CMP;
      dgm_pkg::ST_ADD_CMP:
        state_nxt = st.grp_hit ? dgm_pkg::ST_RESULT : dgm_pkg::ST_ADD_RD;
      dgm_pkg::ST_ADD_WR: state_nxt = dgm_pkg::ST_RESULT;
      dgm_pkg::ST_ADD_NEW: state_nxt = dgm_pkg::ST_RESULT;
      dgm_pkg::ST_RM_RD:
        state_nxt = st.j_at_cnt ? dgm_pkg::ST_RESULT : dgm_pkg::ST_RM_CMP;
      dgm_pkg::ST_RM_CMP:
        state_nxt = st.grp_hit ? (st.j1_at_cnt ? dgm_pkg::ST_RM_DONE : dgm_pkg::ST_SH_RD)
                               : dgm_pkg::ST_RM_RD;
      dgm_pkg::ST_SH_RD: state_nxt = dgm_pkg::ST_SH_WR;
      dgm_pkg::ST_SH_WR:
        state_nxt = st.j1_at_cnt ? dgm_pkg::ST_RM_DONE : dgm_pkg::ST_SH_RD;
      dgm_pkg::ST_RM_DONE:
        state_nxt = st.cnt_is_one ? dgm_pkg::ST_FG_RD : dgm_pkg::ST_RESULT;
      dgm_pkg::ST_FG_RD: state_nxt = dgm_pkg::ST_FG_WR;
      dgm_pkg::ST_FG_WR: begin
        if (!st.slot_is_last) state_nxt = dgm_pkg::ST_CP_RD;
        else if (st.cmd == dgm_pkg::CmdSet && st.group_present) state_nxt = dgm_pkg::ST_SRCH_RD;
        else state_nxt = dgm_pkg::ST_RESULT;
      end
      dgm_pkg::ST_CP_RD: state_nxt = dgm_pkg::ST_CP_WR;
      dgm_pkg::ST_CP_WR: begin
        if (!st.j1_at_cnt) state_nxt = dgm_pkg::ST_CP_RD;
        else if (st.cmd == dgm_pkg::CmdSet && st.group_present) state_nxt = dgm_pkg::ST_SRCH_RD;
        else state_nxt = dgm_pkg::ST_RESULT;
      end
      dgm_pkg::ST_LS_RD:
        state_nxt = st.list_zero ? dgm_pkg::ST_RESULT : dgm_pkg::ST_LS_OUT;
      dgm_pkg::ST_LS_OUT:
        if (!st.out_busy) state_nxt = st.list_last ? dgm_pkg::ST_IDLE : dgm_pkg::ST_LS_RD;
      dgm_pkg::ST_RESULT: if (!st.out_busy) state_nxt = dgm_pkg::ST_IDLE;
      default: state_nxt = dgm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_stall = 1'b1;
    unique case (state_r)
      dgm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load_in = in_valid;
        ctl.srch_clr = 1'b1;
        ctl.ch_clr = 1'b1;
        ctl.fg_phase_clr = 1'b1;
      end
      dgm_pkg::ST_SRCH_RD: ctl.key_rd = 1'b1;
      dgm_pkg::ST_SRCH_CMP: begin
        ctl.found_set = st.key_hit;
        ctl.srch_inc = !st.key_hit;
      end
      dgm_pkg::ST_DISPATCH: begin
        ctl.j_clr = 1'b1;
        ctl.cnt_rd = st.found;
        if (st.cmd == dgm_pkg::CmdSet && !st.fg_phase) begin
          if (!st.set_first) begin
            ctl.fg_phase_set = 1'b1;
            ctl.srch_clr = st.group_present;
          end else if (!st.found) begin
            ctl.set_flag_ld = 1'b1;
            ctl.fg_phase_set = 1'b1;
            ctl.srch_clr = 1'b1;
          end
        end
      end
      dgm_pkg::ST_ADD_RD: ;
      dgm_pkg::ST_ADD_CMP: ctl.j_inc = !st.grp_hit;
      dgm_pkg::ST_ADD_WR: if (!st.cnt_full) begin
        ctl.grp_wr_cnt = 1'b1; ctl.cnt_wr_inc = 1'b1; ctl.ch_set = 1'b1;
      end
      dgm_pkg::ST_ADD_NEW: begin
        ctl.new_dev = 1'b1; ctl.grp_wr_new = 1'b1; ctl.ch_set = 1'b1;
      end
      dgm_pkg::ST_RM_RD: ;
      dgm_pkg::ST_RM_CMP: begin
        ctl.j_inc = !st.grp_hit;
        ctl.grp_rd_j1 = st.grp_hit;
      end
      dgm_pkg::ST_SH_RD: ctl.grp_rd_j1 = 1'b1;
      dgm_pkg::ST_SH_WR: begin
        ctl.grp_wr_j = 1'b1; ctl.j_inc = 1'b1; ctl.grp_rd_j1 = 1'b1;
      end
      dgm_pkg::ST_RM_DONE: begin
        ctl.cnt_wr_dec = 1'b1; ctl.ch_set = 1'b1;
      end
      dgm_pkg::ST_FG_RD: begin
        ctl.last_rd = 1'b1; ctl.ch_set = 1'b1; ctl.j_clr = 1'b1;
      end
      dgm_pkg::ST_FG_WR: begin
        ctl.mv_wr = !st.slot_is_last;
        ctl.dev_dec = st.slot_is_last;
        ctl.cp_rd = 1'b1;
        if (st.cmd == dgm_pkg::CmdSet) begin
          ctl.set_flag_ld = 1'b1;
          if (st.slot_is_last) begin
            ctl.fg_phase_set = 1'b1; ctl.srch_clr = 1'b1; ctl.ch_clr = 1'b1;
          end
        end
      end
      dgm_pkg::ST_CP_RD: ctl.cp_rd = 1'b1;
      dgm_pkg::ST_CP_WR: begin
        ctl.cp_wr = 1'b1; ctl.j_inc = 1'b1; ctl.cp_rd = 1'b1;
        if (st.j1_at_cnt && st.cmd == dgm_pkg::CmdSet) begin
          ctl.fg_phase_set = 1'b1; ctl.srch_clr = 1'b1; ctl.ch_clr = 1'b1;
        end
      end
      dgm_pkg::ST_LS_RD: ;
      dgm_pkg::ST_LS_OUT: if (!st.out_busy) begin
        ctl.out_load = 1'b1; ctl.out_list = 1'b1; ctl.j_inc = 1'b1;
      end
      dgm_pkg::ST_RESULT: if (!st.out_busy) begin
        ctl.out_load = 1'b1;
        ctl.set_flag_or = st.cmd == dgm_pkg::CmdSet && st.fg_phase;
      end
      default: ;
    endcase
  end

  a_idle_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == dgm_pkg::ST_IDLE) else $error("accept outside idle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_in |=> state_r == dgm_pkg::ST_SRCH_RD) else $error("load did not start search");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.new_dev, ctl.mv_wr, ctl.cnt_wr_inc, ctl.cnt_wr_dec}))
    else $error("count ram double write");
endmodule
`default_nettype wire

// ===== rtl/device_group_membership_table.sv =====
// top level of the device group membership table: controller plus datapath
// depends on dgm_pkg, dgm_ctrl, dgm_dp and dgm_ram
`default_nettype none
// The table holds up to 32 devices, each a 64-bit key with an ordered list of
// up to 16 group ids, kept in three block rams (keys, counts, lists) with a
// registered read. One command is in work at a time; in_stall is high from
// the accepting beat until the last result beat is loaded. The cost per
// command is set by the linear key search over the stored devices, plus
// the list entries scanned, shifted or copied: an add to a known device
// scans its list for a duplicate, a forget also moves the last device's
// list into the freed slot, and a list reads each entry before its beat.
// A set element with set_first runs a forget then, with a group present, a
// second search for the add. Results go out through a one-beat output
// register; the next command is accepted while the final beat still waits.
// No clearing pass follows reset: entries are only read below the device
// count and a device's group count, so the rams need no initialization.
module device_group_membership_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [63:0] in_device_address,
  input  wire logic [15:0] in_group_id,
  input  wire logic        in_set_first,
  input  wire logic        in_group_present,
  input  wire logic [4:0]  in_list_limit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_changed,
  output logic [15:0]      out_listed_group,
  output logic             out_listed_valid,
  output logic [4:0]       out_list_count,
  output logic             out_last
);
  dgm_pkg::dgm_cmd_t  ctl;
  dgm_pkg::dgm_stat_t st;

  // sequencing of search, edit and result beats
  dgm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .st(st), .ctl(ctl));

  // storage, indexes and output register
  dgm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st),
    .in_command(in_command), .in_device_address(in_device_address),
    .in_group_id(in_group_id), .in_set_first(in_set_first),
    .in_group_present(in_group_present), .in_list_limit(in_list_limit),
    .out_valid(out_valid), .out_stall(out_stall), .out_changed(out_changed),
    .out_listed_group(out_listed_group), .out_listed_valid(out_listed_valid),
    .out_list_count(out_list_count), .out_last(out_last));
endmodule
`default_nettype wire

// ===== bench/device_group_membership_table_tb.sv =====
// testbench for the device group membership table: directed and random commands
// checked beat by beat against a behavioral model of the table
// depends on dgm_pkg and the device_group_membership_table rtl
`timescale 1ns / 100ps
`default_nettype none
module device_group_membership_table_tb;

  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] addr;
    logic [15:0] gid;
    logic        first;
    logic        present;
    logic [4:0]  limit;
  } cmd_beat_t;

  typedef struct packed {
    logic        changed;
    logic [15:0] grp;
    logic        gvalid;
    logic [4:0]  cnt;
    logic        last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [63:0] in_device_address = '0;
  logic [15:0] in_group_id = '0;
  logic in_set_first = 1'b0;
  logic in_group_present = 1'b0;
  logic [4:0] in_list_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_changed;
  logic [15:0] out_listed_group;
  logic out_listed_valid;
  logic [4:0] out_list_count;
  logic out_last;

  device_group_membership_table DUT (.*);

  // pending command beats and expected answer beats
  cmd_beat_t pending_cmds[$];
  answer_t   expected_answers[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;        // no idling near the end
  bit hold_req = 1'b0;    // ask the receiver for a long hold-off
  bit hold_done = 1'b0;

  // shadow copy of the table
  int          tbl_devices;
  logic [63:0] tbl_keys[dgm_pkg::MaxDevices];
  int          tbl_cnt[dgm_pkg::MaxDevices];
  logic [15:0] tbl_grp[dgm_pkg::MaxDevices][dgm_pkg::MaxGroups];
  bit          run_flag;

  initial forever #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < tbl_devices; i++)
      if (tbl_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic bit drop_device(logic [63:0] k);
    int s;
    int l;
    s = slot_of(k);
    if (s < 0) return 0;
    l = tbl_devices - 1;
    tbl_keys[s] = tbl_keys[l];
    tbl_cnt[s] = tbl_cnt[l];
    tbl_grp[s] = tbl_grp[l];
    tbl_devices = l;
    return 1;
  endfunction

  function automatic bit join_group(logic [63:0] k, logic [15:0] g);
    int s;
    s = slot_of(k);
    if (s >= 0) begin
      for (int j = 0; j < tbl_cnt[s]; j++)
        if (tbl_grp[s][j] == g) return 0;
      if (tbl_cnt[s] >= dgm_pkg::MaxGroups) return 0;
      tbl_grp[s][tbl_cnt[s]] = g;
      tbl_cnt[s]++;
      return 1;
    end
    if (tbl_devices >= dgm_pkg::MaxDevices) return 0;
    tbl_keys[tbl_devices] = k;
    tbl_cnt[tbl_devices] = 1;
    tbl_grp[tbl_devices][0] = g;
    tbl_devices++;
    return 1;
  endfunction

  function automatic bit leave_group(logic [63:0] k, logic [15:0] g);
    int s;
    bit gone;
    s = slot_of(k);
    if (s < 0) return 0;
    for (int j = 0; j < tbl_cnt[s]; j++) begin
      if (tbl_grp[s][j] == g) begin
        for (int m = j; m + 1 < tbl_cnt[s]; m++) tbl_grp[s][m] = tbl_grp[s][m + 1];
        tbl_cnt[s]--;
        if (tbl_cnt[s] == 0) gone = drop_device(k);
        return 1;
      end
    end
    return 0;
  endfunction

  // work out the answer beats of one accepted command
  task automatic predict_answers(cmd_beat_t c);
    answer_t a;
    int s;
    int n;
    a = '0;
    a.last = 1'b1;
    case (c.command)
      dgm_pkg::CmdAdd:    a.changed = join_group(c.addr, c.gid);
      dgm_pkg::CmdRemove: a.changed = leave_group(c.addr, c.gid);
      dgm_pkg::CmdForget: a.changed = drop_device(c.addr);
      dgm_pkg::CmdSet: begin
        if (c.first) run_flag = drop_device(c.addr);
        if (c.present) run_flag = join_group(c.addr, c.gid) | run_flag;
        a.changed = run_flag;
      end
      dgm_pkg::CmdList: begin
        s = slot_of(c.addr);
        n = (s < 0) ? 0 : tbl_cnt[s];
        if (n > c.limit) n = c.limit;
        for (int j = 0; j < n; j++) begin
          a.grp = tbl_grp[s][j];
          a.gvalid = 1'b1;
          a.cnt = n[4:0];
          a.last = (j + 1 == n);
          if (j + 1 < n) expected_answers.push_back(a);
        end
      end
      default: ;
    endcase
    expected_answers.push_back(a);
  endtask

  task automatic report_mismatch(string what, answer_t got, answer_t want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // driver: one beat offered at a time, changes at the falling edge
  int send_gap = 0;
  int offered_count = 0;
  int accepted_count = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && accepted_count != offered_count)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 15);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          offered_count <= offered_count + 1;
          {in_command, in_device_address, in_group_id, in_set_first,
           in_group_present, in_list_limit} <= pending_cmds.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction happens at the accepting edge, so order matches the block
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      accepted_count <= accepted_count + 1;
      predict_answers({in_command, in_device_address, in_group_id, in_set_first,
                       in_group_present, in_list_limit});
    end
  end

  // receiver stall: random bursts plus one long hold-off on request
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= 300;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each answer beat with the oldest expectation
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_changed, out_listed_group, out_listed_valid, out_list_count, out_last};
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected beat", got, '0);
      end else begin
        want = expected_answers.pop_front();
        if (got.changed !== want.changed) report_mismatch("changed", got, want);
        if (got.grp !== want.grp) report_mismatch("listed_group", got, want);
        if (got.gvalid !== want.gvalid) report_mismatch("listed_valid", got, want);
        if (got.cnt !== want.cnt) report_mismatch("list_count", got, want);
        if (got.last !== want.last) report_mismatch("last", got, want);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("device_group_membership_table_tb: FAIL");
      $finish;
    end
  end

  function automatic cmd_beat_t mk(logic [2:0] c, logic [63:0] a, logic [15:0] g,
                                   logic f, logic p, logic [4:0] l);
    mk = '{command: c, addr: a, gid: g, first: f, present: p, limit: l};
  endfunction

  // small pool of keys so that commands hit known devices
  logic [63:0] key_pool[40];

  function automatic cmd_beat_t random_cmd();
    logic [63:0] k;
    logic [2:0] c;
    int r;
    k = key_pool[$urandom_range(0, 39)];
    r = $urandom_range(0, 99);
    if (r < 40) c = dgm_pkg::CmdAdd;
    else if (r < 55) c = dgm_pkg::CmdRemove;
    else if (r < 62) c = dgm_pkg::CmdForget;
    else if (r < 80) c = dgm_pkg::CmdList;
    else if (r < 97) c = dgm_pkg::CmdSet;
    else c = 3'($urandom_range(5, 7));
    return mk(c, k, 16'($urandom_range(0, 19)) ^ ($urandom_range(0, 9) == 0 ?
              16'($urandom) : 16'h0), 1'($urandom), $urandom_range(0, 5) != 0,
              5'($urandom_range(0, 16)));
  endfunction

  initial begin
    tbl_devices = 0;
    run_flag = 0;
    for (int i = 0; i < 40; i++)
      key_pool[i] = (i == 0) ? 64'h0 : (i == 1) ? '1 : {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command and the special cases
    pending_cmds.push_back(mk(dgm_pkg::CmdList, 64'h0, 16'h0, 0, 0, 5'd16));  // unknown device
    pending_cmds.push_back(mk(dgm_pkg::CmdRemove, 64'h0, 16'h0, 0, 0, 0));    // unknown device
    pending_cmds.push_back(mk(dgm_pkg::CmdForget, '1, 16'h0, 0, 0, 0));
    pending_cmds.push_back(mk(dgm_pkg::CmdAdd, '1, 16'hffff, 0, 0, 0));
    pending_cmds.push_back(mk(dgm_pkg::CmdAdd, '1, 16'hffff, 0, 0, 0));       // duplicate
    for (int g = 0; g < 17; g++)                                              // fill, then refuse
      pending_cmds.push_back(mk(dgm_pkg::CmdAdd, 64'h0, 16'(g), 0, 0, 0));
    pending_cmds.push_back(mk(dgm_pkg::CmdList, 64'h0, 16'h0, 0, 0, 5'd0));   // zero limit
    pending_cmds.push_back(mk(dgm_pkg::CmdList, 64'h0, 16'h0, 0, 0, 5'd16));
    pending_cmds.push_back(mk(dgm_pkg::CmdList, 64'h0, 16'h0, 0, 0, 5'd31));  // limit above cap
    pending_cmds.push_back(mk(dgm_pkg::CmdRemove, 64'h0, 16'd5, 0, 0, 0));    // shift down
    pending_cmds.push_back(mk(dgm_pkg::CmdRemove, 64'h0, 16'd99, 0, 0, 0));   // absent id
    pending_cmds.push_back(mk(dgm_pkg::CmdRemove, '1, 16'hffff, 0, 0, 0));    // drops device
    pending_cmds.push_back(mk(dgm_pkg::CmdSet, 64'h0, 16'h7, 1, 1, 0));
    pending_cmds.push_back(mk(dgm_pkg::CmdSet, 64'h0, 16'h8, 0, 1, 0));       // no forget first
    pending_cmds.push_back(mk(dgm_pkg::CmdSet, 64'h0, 16'h8, 0, 0, 0));       // no group
    pending_cmds.push_back(mk(dgm_pkg::CmdSet, '1, 16'h0, 1, 0, 0));          // empty set
    pending_cmds.push_back(mk(3'd5, '1, '1, 1, 1, 5'h1f));                    // unused codes
    pending_cmds.push_back(mk(3'd7, '1, '1, 1, 1, 5'h1f));
    // fill the table past its device cap
    for (int i = 0; i < 34; i++)
      pending_cmds.push_back(mk(dgm_pkg::CmdAdd, {32'(i), $urandom}, 16'(i), 0, 0, 0));
    for (int i = 0; i < 34; i++)
      pending_cmds.push_back(mk(dgm_pkg::CmdForget, key_pool[i % 4], 16'h0, 0, 0, 0));
    wait (pending_cmds.size() == 0);

    // random commands with a long receiver hold-off partway through
    for (int n = 0; n < 250; n++) begin
      if (n == 100) begin
        wait (pending_cmds.size() == 0);
        hold_req = 1'b1;
      end
      if (n == 200) calm = 1'b1;
      pending_cmds.push_back(random_cmd());
      if (pending_cmds.size() > 8) wait (pending_cmds.size() <= 4);
    end
    wait (pending_cmds.size() == 0 && !in_valid);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("device_group_membership_table_tb: PASS");
    end else begin
      $display("device_group_membership_table_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
